// ===== hdl/psd_pkg.sv =====
// psd_pkg: shared types and constants for the pair sort and dedup block
// no dependencies; imported by psd_cell and pair_sort_dedup
`timescale 1ns / 1ps

package psd_pkg;

	localparam int KEY_W           = 64;
	localparam int ID_W            = 32;
	localparam int DEF_MAX_PAIRS   = 64;

	typedef logic [KEY_W-1:0] key_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic load;
		logic shift;
	} psd_ctl_t;

endpackage

// ===== hdl/pair_sort_dedup.sv =====
// pair_sort_dedup: top level, chain of sorting cells plus drain and dedup output stage
// depends on psd_pkg and psd_cell
`timescale 1ns / 1ps
//
// channel  dir  tdata                                tlast       tuser
// s_*      in   [31:0] first_id, [63:32] second_id   batch_end   -
// m_*      out  [31:0] out_first, [63:32] out_second out_last    [0] overflowed
//
// loading takes one pair per cycle, inserted into all cells at once
// after the pair with tlast, the chain drains one cell per cycle toward cell 0
// while draining s_tready is low; m_tready low stalls the drain in place
// reset clears cell valid bits, the drain state and the output valid

module pair_sort_dedup #(
	parameter int MAX_PAIRS = psd_pkg::DEF_MAX_PAIRS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // first_id, second_id
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // out_first, out_second
	output logic        m_tlast,
	output logic [0:0]  m_tuser    // overflowed
);
	import psd_pkg::*;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

	localparam logic [ID_W-1:0] SIGN_FLIP = {1'b1, {(ID_W-1){1'b0}}};

	state_t   state_q;
	psd_ctl_t ctl;
	key_t     in_key;
	key_t     cell_key [MAX_PAIRS];
	logic [MAX_PAIRS-1:0] cell_vld;
	logic [MAX_PAIRS-1:0] cell_gt;
	logic     in_acc;
	logic     full;
	logic     adv;
	logic     ovf_q;
	key_t     pend_q;
	logic     pend_vld_q;
	logic     out_vld_q;
	key_t     out_key_q;
	logic     out_last_q;
	logic     out_ovf_q;

	assign in_key   = {s_tdata[ID_W-1:0] ^ SIGN_FLIP, s_tdata[2*ID_W-1:ID_W] ^ SIGN_FLIP};
	assign s_tready = (state_q == ST_LOAD);
	assign in_acc   = s_tvalid && s_tready;
	assign full     = cell_vld[MAX_PAIRS-1];
	assign adv      = !out_vld_q || m_tready;

	assign ctl.load  = in_acc && !full;
	assign ctl.shift = (state_q == ST_DRAIN) && adv && cell_vld[0];

	for (genvar i = 0; i < MAX_PAIRS; i++) begin : g_cell
		logic pv, pg, nv;
		key_t pk, nk;
		if (i == 0) begin : g_head
			assign pv = 1'b1;
			assign pg = 1'b0;
			assign pk = in_key;
		end else begin : g_body
			assign pv = cell_vld[i-1];
			assign pg = cell_gt[i-1];
			assign pk = cell_key[i-1];
		end
		if (i == MAX_PAIRS - 1) begin : g_tail
			assign nv = 1'b0;
			assign nk = cell_key[i];
		end else begin : g_mid
			assign nv = cell_vld[i+1];
			assign nk = cell_key[i+1];
		end
		psd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.new_key  (in_key),
			.prev_vld (pv),
			.prev_gt  (pg),
			.prev_key (pk),
			.next_vld (nv),
			.next_key (nk),
			.key_q    (cell_key[i]),
			.vld_q    (cell_vld[i]),
			.gt       (cell_gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			ovf_q      <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
			pend_q     <= '0;
			out_key_q  <= '0;
			out_last_q <= 1'b0;
			out_ovf_q  <= 1'b0;
		end else begin
			if (adv) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (full) begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (adv) begin
						if (cell_vld[0]) begin
							if (!(pend_vld_q && cell_key[0] == pend_q)) begin
								if (pend_vld_q) begin
									out_vld_q  <= 1'b1;
									out_key_q  <= pend_q;
									out_last_q <= 1'b0;
									out_ovf_q  <= ovf_q;
								end
								pend_q     <= cell_key[0];
								pend_vld_q <= 1'b1;
							end
						end else begin
							out_vld_q  <= 1'b1;
							out_key_q  <= pend_q;
							out_last_q <= 1'b1;
							out_ovf_q  <= ovf_q;
							pend_vld_q <= 1'b0;
							ovf_q      <= 1'b0;
							state_q    <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_key_q[ID_W-1:0] ^ SIGN_FLIP, out_key_q[KEY_W-1:ID_W] ^ SIGN_FLIP};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_ovf_q;

	logic [MAX_PAIRS:0] vld_inc;
	assign vld_inc = {1'b0, cell_vld} + {{MAX_PAIRS{1'b0}}, 1'b1};

	a_vld_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_inc[MAX_PAIRS-1:0] & cell_vld) == '0)
		else $error("cell valid bits not packed toward cell 0");

	a_pend_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN && !cell_vld[0]) |-> pend_vld_q)
		else $error("drain ended with no pending pair");

	a_load_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> !pend_vld_q)
		else $error("pending pair left over while loading");

	a_full_sets_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && full) |=> ovf_q || (state_q == ST_DRAIN && $past(s_tlast) && ovf_q))
		else $error("dropped pair did not set overflow");

endmodule

// ===== hdl/psd_cell.sv =====
// psd_cell: one slot of the insertion sorting chain, holds one packed pair key
// depends on psd_pkg
`timescale 1ns / 1ps

module psd_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  psd_pkg::psd_ctl_t ctl,
	input  psd_pkg::key_t   new_key,
	input  logic            prev_vld,
	input  logic            prev_gt,
	input  psd_pkg::key_t   prev_key,
	input  logic            next_vld,
	input  psd_pkg::key_t   next_key,
	output psd_pkg::key_t   key_q,
	output logic            vld_q,
	output logic            gt
);
	import psd_pkg::*;

	assign gt = vld_q && (key_q > new_key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.shift) begin
			vld_q <= next_vld;
		end else if (ctl.load) begin
			if (prev_gt || gt || (!vld_q && prev_vld)) begin
				vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			key_q <= next_key;
		end else if (ctl.load) begin
			if (prev_gt) begin
				key_q <= prev_key;
			end else if (gt || (!vld_q && prev_vld)) begin
				key_q <= new_key;
			end
		end
	end

endmodule
